FILE: rtl/core/rrw_pkg.sv
// shared types and constants for the receive reorder window
package rrw_pkg;

  localparam int SEQ_W  = 32;
  localparam int WIN_W  = 7;
  localparam int FLAG_W = 3;

  localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;
  localparam logic [SEQ_W-1:0] EXP_RESET = 32'd1;

  // item kind carried on tuser of the input channel
  typedef enum logic {
    OP_DATA = 1'b0,
    OP_ACK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;    // latch the accepted input item
    logic eval;       // classify the item and update state
    logic walk;       // clear the marked head slot and step past it
    logic load;       // move the finished result into the output register
  } rrw_cmd_t;

  typedef struct packed {
    logic walk_start;  // in-order data item, head walk follows
    logic head_marked; // slot at the head is marked
    logic out_space;   // output register free this cycle
  } rrw_sts_t;

endpackage

FILE: rtl/core/rrw_ctrl.sv
// controller state machine of the receive reorder window
module rrw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rrw_pkg::rrw_sts_t sts,
  output rrw_pkg::rrw_cmd_t cmd
);
  import rrw_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = sts.walk_start ? ST_WALK : ST_FIN;
      end
      ST_WALK: begin
        if (!sts.head_marked) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_space) state_nxt = in_tvalid ? ST_EVAL : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.eval    = 1'b0;
    cmd.walk    = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_WALK: begin
        cmd.walk = sts.head_marked;
      end
      ST_FIN: begin
        // next item may enter as the result leaves
        in_tready = sts.out_space;
        cmd.load  = sts.out_space;
      end
      default: in_tready = 1'b0;
    endcase
    cmd.capture = in_tvalid && in_tready;
  end

endmodule

FILE: rtl/core/rrw_dp.sv
// datapath of the receive reorder window: bitmap, head, expected number, result register
module rrw_dp #(
  parameter int WINDOW_SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rrw_pkg::SEQ_W-1:0]  in_tdata,
  input  logic                       in_tuser,
  input  logic                       cfg_wr_en,
  input  logic [rrw_pkg::WIN_W-1:0]  cfg_wr_data,
  input  rrw_pkg::rrw_cmd_t          cmd,
  output rrw_pkg::rrw_sts_t          sts,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rrw_pkg::SEQ_W-1:0]  out_tdata,
  output logic [rrw_pkg::FLAG_W-1:0] out_tuser
);
  import rrw_pkg::*;

  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int SUM_W  = SLOT_W + 1;

  logic [WIN_W-1:0]        win_r;
  logic [WINDOW_SLOTS-1:0] map_r;
  logic [SLOT_W-1:0]       head_r;
  logic [SEQ_W-1:0]        exp_r;
  logic                    owed_r;

  logic [SEQ_W-1:0]        seq_r;
  op_t                     op_r;

  logic                    res_due_r;
  logic                    res_dup_r;
  logic                    res_rej_r;

  logic                    out_valid_r;
  logic [SEQ_W-1:0]        out_data_r;
  logic [FLAG_W-1:0]       out_user_r;

  logic [SUM_W-1:0]        w_act;
  logic [SEQ_W-1:0]        gap;
  logic                    is_old;
  logic                    beyond;
  logic                    in_order;
  logic [SUM_W-1:0]        slot_sum;
  logic [SLOT_W-1:0]       mark_slot;
  logic [SUM_W-1:0]        head_inc;
  logic [SLOT_W-1:0]       head_next;

  // effective window: zero acts as one, above the ring size acts as the ring size
  always_comb begin
    if (win_r == '0) begin
      w_act = SUM_W'(1);
    end else if (32'(win_r) > 32'(WINDOW_SLOTS)) begin
      w_act = SUM_W'(WINDOW_SLOTS);
    end else begin
      w_act = SUM_W'(win_r);
    end
  end

  always_comb begin
    gap      = seq_r - exp_r;
    is_old   = seq_r < exp_r;
    beyond   = gap >= 32'(w_act);
    in_order = (op_r == OP_DATA) && !is_old && (gap == '0);
    // gap is below the window here, so it fits the slot sum
    slot_sum = {1'b0, head_r} + SUM_W'(gap);
    if (slot_sum >= w_act) begin
      mark_slot = SLOT_W'(slot_sum - w_act);
    end else begin
      mark_slot = SLOT_W'(slot_sum);
    end
    head_inc  = {1'b0, head_r} + SUM_W'(1);
    head_next = (head_inc >= w_act) ? '0 : SLOT_W'(head_inc);
  end

  assign sts.walk_start  = in_order;
  assign sts.head_marked = map_r[head_r];
  assign sts.out_space   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_r <= in_tdata;
      op_r  <= op_t'(in_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WIN_RESET;
      map_r  <= '0;
      head_r <= '0;
      exp_r  <= EXP_RESET;
      owed_r <= 1'b0;
    end else if (cfg_wr_en) begin
      // ring renegotiated: slots and head restart, sequence state kept
      win_r  <= cfg_wr_data;
      map_r  <= '0;
      head_r <= '0;
    end else if (cmd.eval) begin
      if (op_r == OP_ACK) begin
        owed_r <= 1'b0;
      end else if (is_old) begin
        owed_r <= 1'b1;
      end else if (!beyond) begin
        owed_r <= 1'b1;
        if (gap == '0) begin
          head_r <= head_next;
          exp_r  <= exp_r + SEQ_W'(1);
        end else begin
          map_r[mark_slot] <= 1'b1;
        end
      end
    end else if (cmd.walk) begin
      map_r[head_r] <= 1'b0;
      head_r        <= head_next;
      exp_r         <= exp_r + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (op_r == OP_ACK) begin
        res_due_r <= owed_r;
        res_dup_r <= 1'b0;
        res_rej_r <= 1'b0;
      end else begin
        res_dup_r <= is_old;
        res_rej_r <= !is_old && beyond;
        res_due_r <= (!is_old && beyond) ? owed_r : 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= exp_r;
      out_user_r <= {res_rej_r, res_dup_r, res_due_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/core/receive_reorder_window.sv
// Receive reorder window: tracks out-of-order packet arrivals in a ring bitmap and keeps
// the cumulative ack value and an ack-owed flag. One result per input item. An item is
// classified, then its result is handed to the output register once that register has
// space. An in-order data packet adds a head walk that looks at the new head and clears
// each consecutive already-arrived slot that it releases, since the head walk steps over
// the bitmap one slot per cycle. A result held in the output register stalls the next
// transfer until it leaves. Writing the window register clears the bitmap and the head in
// the same cycle; write it only while the block is idle.
module receive_reorder_window #(
  parameter int WINDOW_SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rrw_pkg::SEQ_W-1:0]  in_tdata,   // [31:0] sequence_number
  input  logic                       in_tuser,   // [0] op
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rrw_pkg::SEQ_W-1:0]  out_tdata,  // [31:0] next_expected
  output logic [rrw_pkg::FLAG_W-1:0] out_tuser,  // [0] ack_due, [1] duplicate, [2] rejected
  input  logic                       cfg_wr_en,
  input  logic [rrw_pkg::WIN_W-1:0]  cfg_wr_data // window_in_use
);
  import rrw_pkg::*;

  rrw_cmd_t cmd;
  rrw_sts_t sts;

  rrw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrw_dp #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // output register comes up empty
  a_out_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a packet is never both older than expected and beyond the window
  a_dup_rej_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[2]))
    else $error("duplicate and rejected both set");

  // a duplicate always leaves an ack owed
  a_dup_sets_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tuser[0])
    else $error("duplicate without ack due");

  // an accepted transfer is classified before the next one is taken
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in work");

endmodule

FILE: sim/tb.sv
// testbench for receive_reorder_window: random and directed packet streams checked against a predictor
`timescale 1ns / 1ps

module tb;
  import rrw_pkg::*;

  localparam int SLOTS = 64;

  typedef struct {
    logic [SEQ_W-1:0] next_expected;
    logic             ack_due;
    logic             duplicate;
    logic             rejected;
  } ack_result_t;

  // tracks the reorder window and holds the results still owed by the block
  class reorder_scoreboard;
    bit [WIN_W-1:0] win_reg;
    bit             arrived [SLOTS];
    int unsigned    head;
    bit [SEQ_W-1:0] expected;
    bit             owed;
    int             errors;
    ack_result_t    owed_results [$];

    function new();
      win_reg  = WIN_RESET;
      head     = 0;
      expected = EXP_RESET;
      owed     = 1'b0;
      errors   = 0;
      foreach (arrived[i]) arrived[i] = 1'b0;
    endfunction

    function int unsigned active();
      if (win_reg == 0) return 1;
      if (win_reg > SLOTS) return SLOTS;
      return win_reg;
    endfunction

    function int unsigned step_head(int unsigned p, int unsigned w);
      return (p + 1 >= w) ? 0 : p + 1;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // renegotiated ring: bitmap and head cleared, sequence state kept
    function void set_window(bit [WIN_W-1:0] v);
      win_reg = v;
      head    = 0;
      foreach (arrived[i]) arrived[i] = 1'b0;
    endfunction

    function void note(op_t op, bit [SEQ_W-1:0] seq);
      int unsigned w;
      bit [SEQ_W-1:0] gap;
      int unsigned slot;
      int unsigned n;
      ack_result_t r;
      r.duplicate = 1'b0;
      r.rejected  = 1'b0;
      if (op == OP_ACK) begin
        r.ack_due = owed;
        owed = 1'b0;
      end else begin
        w = active();
        if (head >= w) head = 0;
        if (seq < expected) begin
          r.duplicate = 1'b1;
          owed = 1'b1;
        end else begin
          gap = seq - expected;
          if (gap >= w) begin
            r.rejected = 1'b1;
          end else if (gap == 0) begin
            head = step_head(head, w);
            expected = expected + 1;
            // release every consecutive packet that arrived early
            for (n = 0; n < w && arrived[head]; n++) begin
              arrived[head] = 1'b0;
              head = step_head(head, w);
              expected = expected + 1;
            end
            owed = 1'b1;
          end else begin
            slot = head + gap;
            if (slot >= w) slot -= w;
            arrived[slot] = 1'b1;
            owed = 1'b1;
          end
        end
        r.ack_due = owed;
      end
      r.next_expected = expected;
      owed_results.push_back(r);
    endfunction

    function void check(logic [SEQ_W-1:0] data, logic [FLAG_W-1:0] user);
      ack_result_t e;
      if (owed_results.size() == 0) begin
        $error("result transfer with nothing expected: next_expected %0h flags %b", data, user);
        errors++;
        return;
      end
      e = owed_results.pop_front();
      if (data !== e.next_expected) begin
        $error("next_expected: expected %0h, actual %0h", e.next_expected, data);
        errors++;
      end
      if (user[0] !== e.ack_due) begin
        $error("ack_due: expected %b, actual %b", e.ack_due, user[0]);
        errors++;
      end
      if (user[1] !== e.duplicate) begin
        $error("duplicate: expected %b, actual %b", e.duplicate, user[1]);
        errors++;
      end
      if (user[2] !== e.rejected) begin
        $error("rejected: expected %b, actual %b", e.rejected, user[2]);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [SEQ_W-1:0]   in_tdata = '0;   // [31:0] sequence_number
  logic               in_tuser = 1'b0; // [0] op
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [SEQ_W-1:0]   out_tdata;       // [31:0] next_expected
  logic [FLAG_W-1:0]  out_tuser;       // [0] ack_due, [1] duplicate, [2] rejected
  logic               cfg_wr_en = 1'b0;
  logic [WIN_W-1:0]   cfg_wr_data = '0;

  int send_idle = 7;
  int recv_idle = 85;

  reorder_scoreboard sb = new();

  receive_reorder_window #(.WINDOW_SLOTS(SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check the transfer seen at this edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_item(input op_t op, input logic [SEQ_W-1:0] seq);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= seq;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note(op, seq);
  endtask

  // idle the input and let every owed result come out (the head walk ends before its result)
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_window(v);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic pick_packet(output op_t op, output logic [SEQ_W-1:0] seq);
    int unsigned w;
    int unsigned r;
    logic [SEQ_W-1:0] e;
    w  = sb.active();
    e  = sb.expected;
    r  = $urandom_range(99);
    op = OP_DATA;
    if (r < 10) begin
      op  = OP_ACK;
      seq = $urandom;
    end else if (r < 30) begin
      seq = e;
    end else if (r < 75) begin
      seq = e + ((w > 1) ? $urandom_range(1, w - 1) : 0);
    end else if (r < 87) begin
      seq = ($urandom_range(1) == 1) ? e - 1 : $urandom_range(0, e - 1);
    end else if (r < 95) begin
      // last slot of the window or the first one past it
      seq = e + w - 1 + $urandom_range(1);
    end else begin
      seq = $urandom;
    end
  endtask

  initial begin
    op_t op;
    logic [SEQ_W-1:0] seq;
    logic [WIN_W-1:0] win_plan [9];
    win_plan = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd33, 7'd100, 7'd3, 7'd1};
    win_plan[8] = $urandom_range(1, SLOTS);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_ACK, '0);
    send_item(OP_DATA, '0);
    send_item(OP_DATA, 32'd1);
    send_item(OP_DATA, '1);
    send_item(OP_DATA, sb.expected + 63);
    send_item(OP_DATA, sb.expected + 64);
    send_item(OP_DATA, sb.expected + 63);
    send_item(OP_ACK, '1);
    send_item(OP_ACK, 32'h5a5a_a5a5);
    for (int k = 1; k <= 3; k++) send_item(OP_DATA, sb.expected + k);
    send_item(OP_DATA, sb.expected);
    send_item(OP_DATA, 32'h8000_0000);
    send_item(OP_DATA, sb.expected - 1);
    settle();
    write_window(7'd1);
    send_item(OP_DATA, sb.expected + 1);
    send_item(OP_DATA, sb.expected);
    send_item(OP_ACK, '0);
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin
          send_idle = 7;
          recv_idle = 85;
        end
        1: begin
          send_idle = 85;
          recv_idle = 7;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_window(win_plan[ph]);
      for (int i = 0; i < 50; i++) begin
        if (ph == 4 && i == 20) settle();
        pick_packet(op, seq);
        send_item(op, seq);
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: receive_reorder_window.f
rtl/core/rrw_pkg.sv
rtl/core/rrw_ctrl.sv
rtl/core/rrw_dp.sv
rtl/core/receive_reorder_window.sv
sim/tb.sv
